>>> hw/rtl/tsr_pkg.sv
// Package: shared constants, types and state codes for the triangle span rasterizer.
package tsr_pkg;
  localparam int COORD_BITS_DEF = 10;
  localparam int COLOUR_BITS = 24;
  localparam int OPC_LOAD = 0;
  localparam int OPC_ADVANCE = 1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SORT,
    ST_DIV,
    ST_SETUP,
    ST_READY,
    ST_STEP1,
    ST_STEP2,
    ST_EMIT
  } tsr_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture input item
    logic sort;       // sort vertices, classify
    logic div_start;  // start split division
    logic div_step;   // one divider step
    logic setup;      // set up current half
    logic snap;       // capture span into output register
    logic dec;        // count down spans, maybe switch half
    logic step1;      // step edge one
    logic step2;      // step edge two once
  } tsr_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic split;      // triangle needs two halves
    logic div_done;
    logic half_end;   // span in hand is the last of its half
    logic final_half;
    logic rows_met;   // edge two on edge one's row or guard hit
  } tsr_sts_t;
endpackage

>>> hw/rtl/tsr_if.sv
// Interface: valid/ready channel carrying a payload of configurable type.
interface tsr_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/tsr_ctrl.sv
// Controller: sequencer for load, division, setup, span emit and edge walking.
module tsr_ctrl import tsr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_opcode,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  tsr_sts_t sts,
  output tsr_cmd_t cmd
);
  tsr_state_t state_r, state_nxt;
  logic active_r, active_nxt;
  logic ovalid_r, ovalid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      active_r <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      active_r <= active_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  assign out_valid = ovalid_r;
  // snap needs a free output slot
  assign in_ready = (state_r == ST_IDLE) &&
                    (!ovalid_r || out_ready || in_opcode == 1'(OPC_LOAD));

  always_comb begin
    state_nxt  = state_r;
    active_nxt = active_r;
    ovalid_nxt = ovalid_r && !out_ready;
    cmd        = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          if (in_opcode == 1'(OPC_LOAD)) begin
            cmd.load  = 1'b1;
            state_nxt = ST_SORT;
          end else if (active_r) begin
            cmd.snap   = 1'b1;
            cmd.dec    = 1'b1;
            ovalid_nxt = 1'b1;
            if (sts.half_end) begin
              // last span of the half: no stepping; datapath starts next half during dec
              if (sts.final_half) active_nxt = 1'b0;
            end else begin
              state_nxt = ST_EMIT;
            end
          end
        end
      end
      ST_SORT: begin
        cmd.sort   = 1'b1;
        active_nxt = 1'b1;
        state_nxt  = ST_DIV;
      end
      ST_DIV: begin
        if (!sts.split) begin
          state_nxt = ST_SETUP;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_READY;
        end
      end
      ST_READY: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_nxt = ST_SETUP;
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_EMIT: begin
        cmd.step1 = 1'b1;
        state_nxt = ST_STEP2;
      end
      ST_STEP2: begin
        if (sts.rows_met) state_nxt = ST_IDLE;
        else cmd.step2 = 1'b1;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

>>> hw/rtl/tsr_dp.sv
// Datapath: vertex sort, split divider, Bresenham walkers and span register.
module tsr_dp import tsr_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                   clk,
  input  logic [COORD_BITS-1:0]  vx_in [3],
  input  logic [COORD_BITS-1:0]  vy_in [3],
  input  logic [COLOUR_BITS-1:0] colour_in,
  input  tsr_cmd_t               cmd,
  input  logic                   rst_n,
  output tsr_sts_t               sts,
  output logic [COORD_BITS-1:0]  o_row,
  output logic [COORD_BITS-1:0]  o_xf,
  output logic [COORD_BITS-1:0]  o_xt,
  output logic [COLOUR_BITS-1:0] o_col,
  output logic                   o_last
);
  localparam int CW = COORD_BITS + 3;        // signed coordinate / delta
  localparam int EW = COORD_BITS + 4;        // error term
  localparam int PW = 2 * COORD_BITS + 1;    // product magnitude
  localparam int DCW = $clog2(PW + 1);
  localparam int GW = COORD_BITS + 3;
  localparam logic [GW-1:0] WALK_CAP = GW'((2 << COORD_BITS) + 2);

  typedef struct packed {
    logic signed [CW-1:0] x, y, dmaj, dmin, sx, sy;
    logic signed [EW-1:0] err;
    logic                 steep;
  } walk_t;

  logic [COORD_BITS-1:0] vx_r [3], vy_r [3];
  logic [COLOUR_BITS-1:0] col_r;
  logic signed [CW-1:0] ax_r, ay_r, bx_r, by_r, cx_r, cy_r;   // current half
  logic signed [CW-1:0] apx_r, apy_r, fx_r, spy_r, spx_r;
  logic split_r, phase_r;
  logic [COORD_BITS:0] steps_r;
  walk_t e1_r, e2_r;
  logic [GW-1:0] guard_r;
  // divider
  logic [PW-1:0] num_r, quo_r;
  logic [COORD_BITS-1:0] den_r;
  logic [PW:0] rem_r;
  logic neg_r;
  logic [DCW-1:0] dcnt_r;

  function automatic walk_t setup_w(logic signed [CW-1:0] ax, ay, bx, by);
    walk_t w;
    logic signed [CW-1:0] dx, dy;
    dx = bx - ax;
    dy = by - ay;
    w.sx = (dx > 0) ? CW'(1) : (dx < 0) ? -CW'(1) : CW'(0);
    w.sy = (dy > 0) ? CW'(1) : (dy < 0) ? -CW'(1) : CW'(0);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    w.steep = dy > dx;
    w.dmaj = w.steep ? dy : dx;
    w.dmin = w.steep ? dx : dy;
    w.err = EW'(2 * EW'(w.dmin) - EW'(w.dmaj));
    w.x = ax;
    w.y = ay;
    return w;
  endfunction

  // guard of at most four inner steps, then one outer step
  function automatic walk_t step_w(walk_t wi);
    walk_t w;
    w = wi;
    if (w.dmaj != 0) begin
      for (int g = 0; g < 4; g++) begin
        if (w.err >= 0) begin
          if (w.steep) w.x = w.x + w.sx; else w.y = w.y + w.sy;
          w.err = EW'(w.err - 2 * EW'(w.dmaj));
        end
      end
      if (w.steep) w.y = w.y + w.sy; else w.x = w.x + w.sx;
      w.err = EW'(w.err + 2 * EW'(w.dmin));
    end
    return w;
  endfunction

  // sort network (stable insertion, descending y)
  logic [COORD_BITS-1:0] sx_c [3], sy_c [3], tx, ty;
  always_comb begin
    sx_c = vx_r;
    sy_c = vy_r;
    if (sy_c[0] < sy_c[1]) begin
      tx = sx_c[0]; sx_c[0] = sx_c[1]; sx_c[1] = tx;
      ty = sy_c[0]; sy_c[0] = sy_c[1]; sy_c[1] = ty;
    end
    if (sy_c[1] < sy_c[2]) begin
      tx = sx_c[1]; sx_c[1] = sx_c[2]; sx_c[2] = tx;
      ty = sy_c[1]; sy_c[1] = sy_c[2]; sy_c[2] = ty;
    end
    if (sy_c[0] < sy_c[1]) begin
      tx = sx_c[0]; sx_c[0] = sx_c[1]; sx_c[1] = tx;
      ty = sy_c[0]; sy_c[0] = sy_c[1]; sy_c[1] = ty;
    end
    tx = '0;
    ty = '0;
  end

  logic signed [CW-1:0] sxs [3], sys [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sxs[i] = CW'(sx_c[i]);
      sys[i] = CW'(sy_c[i]);
    end
  end

  // split division: (y0-y1)*(x0-x2) / (y0-y2), y0>y1>y2
  logic signed [CW-1:0] dxa;
  logic [COORD_BITS-1:0] dxm;
  logic [PW:0] rem_sh;
  logic [PW-1:0] q_nxt;
  logic signed [CW-1:0] q_s;
  always_comb begin
    dxa = ax_r - CW'(vx_r[2]);
    dxm = dxa[CW-1] ? COORD_BITS'(-dxa) : COORD_BITS'(dxa);
    rem_sh = {rem_r[PW-1:0], num_r[PW-1]};
    q_nxt = {quo_r[PW-2:0], rem_sh >= (PW+1)'(den_r)};
    q_s = neg_r ? -CW'(q_nxt) : CW'(q_nxt);
  end

  walk_t e1_n, e2_n;
  always_comb begin
    e1_n = step_w(e1_r);
    e2_n = step_w(e2_r);
  end

  // edge setup for the current half and for the lower half
  walk_t e1_s, e2_s, e1_h, e2_h;
  always_comb begin
    e1_s = setup_w(ax_r, ay_r, bx_r, by_r);
    e2_s = setup_w(ax_r, ay_r, cx_r, cy_r);
    e1_h = setup_w(apx_r, apy_r, fx_r, spy_r);
    e2_h = setup_w(apx_r, apy_r, spx_r, spy_r);
  end

  assign sts.div_done = (dcnt_r == '0);
  assign sts.split = split_r;
  assign sts.final_half = phase_r;
  assign sts.half_end = (steps_r <= (COORD_BITS+1)'(1));
  assign sts.rows_met = (e2_r.y == e1_r.y) || (guard_r == WALK_CAP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
      steps_r <= '0;
      dcnt_r  <= '0;
    end else begin
      if (cmd.load) begin
        vx_r  <= vx_in;
        vy_r  <= vy_in;
        col_r <= colour_in;
      end
      if (cmd.sort) begin
        // ax/ay hold the apex of the current half (v0, or v2 for a flat top); vx_r/vy_r become sorted
        vx_r <= sx_c;
        vy_r <= sy_c;
        if (sy_c[1] == sy_c[2]) begin
          split_r <= 1'b0; phase_r <= 1'b1;
          ax_r <= sxs[0]; ay_r <= sys[0]; bx_r <= sxs[1]; by_r <= sys[1];
          cx_r <= sxs[2]; cy_r <= sys[2];
        end else if (sy_c[0] == sy_c[1]) begin
          split_r <= 1'b0; phase_r <= 1'b1;
          ax_r <= sxs[2]; ay_r <= sys[2]; bx_r <= sxs[0]; by_r <= sys[0];
          cx_r <= sxs[1]; cy_r <= sys[1];
        end else begin
          split_r <= 1'b1; phase_r <= 1'b0;
          ax_r <= sxs[0]; ay_r <= sys[0]; bx_r <= sxs[1]; by_r <= sys[1];
          apx_r <= sxs[2]; apy_r <= sys[2]; fx_r <= sxs[1]; spy_r <= sys[1];
          cy_r <= sys[1];
        end
      end
      if (cmd.div_start) begin
        num_r  <= PW'(COORD_BITS'(vy_r[0] - vy_r[1]) * dxm);
        den_r  <= vy_r[0] - vy_r[2];
        neg_r  <= dxa[CW-1];
        rem_r  <= '0;
        quo_r  <= '0;
        dcnt_r <= DCW'(PW);
      end else if (cmd.div_step && dcnt_r != '0) begin
        num_r <= num_r << 1;
        if (rem_sh >= (PW+1)'(den_r)) begin
          rem_r <= rem_sh - (PW+1)'(den_r);
        end else begin
          rem_r <= rem_sh;
        end
        quo_r  <= q_nxt;
        dcnt_r <= dcnt_r - 1'b1;
        if (dcnt_r == DCW'(1)) begin
          cx_r  <= ax_r - q_s;
          spx_r <= ax_r - q_s;
        end
      end
      if (cmd.setup) begin
        e1_r    <= e1_s;
        e2_r    <= e2_s;
        steps_r <= (COORD_BITS+1)'(e1_s.dmaj) + 1'b1;
      end
      if (cmd.snap) begin
        o_row  <= COORD_BITS'(e1_r.y);
        o_xf   <= COORD_BITS'(e1_r.x);
        o_xt   <= COORD_BITS'(e2_r.x);
        o_col  <= col_r;
        o_last <= phase_r && (steps_r <= (COORD_BITS+1)'(1));
      end
      if (cmd.dec) begin
        if (steps_r > (COORD_BITS+1)'(1)) begin
          steps_r <= steps_r - 1'b1;
        end else if (!phase_r) begin
          // lower half: apex v2, edges to the middle vertex and the split point
          phase_r <= 1'b1;
          e1_r    <= e1_h;
          e2_r    <= e2_h;
          steps_r <= (COORD_BITS+1)'(e1_h.dmaj) + 1'b1;
        end else begin
          steps_r <= '0;
        end
      end
      if (cmd.step1) begin
        e1_r    <= e1_n;
        guard_r <= '0;
      end
      if (cmd.step2) begin
        e2_r    <= e2_n;
        guard_r <= guard_r + 1'b1;
      end
    end
  end
endmodule

>>> hw/rtl/triangle_span_rasterizer.sv
// Top level: triangle span rasterizer with valid/ready input and span channels.
//
// Input channel (in_*): opcode 0 loads a triangle (three vertices, colour);
// opcode 1 asks for the next horizontal span. Output channel (out_*) carries
// one span (row, x from, x to, colour, last flag) per advance while a
// triangle is active; advances with no triangle give nothing, and a load
// drops any triangle in progress.
// A load keeps the input busy through sort and setup and, when the triangle
// is split, the bit-serial split divider (one quotient bit a cycle).
// An advance puts its span in the output register at its transfer edge, so
// out_valid rises the next cycle. The last span of a half frees the input at
// once; any other span then steps edge one once and edge two one Bresenham
// step a cycle until rows meet, and the input stays busy until then.
// Reset clears the controller and drops any triangle. A stalled receiver
// holds the span register; the next advance waits until it is taken, while
// a load is still accepted.
module triangle_span_rasterizer import tsr_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_opcode,
  input  logic [COORD_BITS-1:0]  in_first_x,
  input  logic [COORD_BITS-1:0]  in_first_y,
  input  logic [COORD_BITS-1:0]  in_second_x,
  input  logic [COORD_BITS-1:0]  in_second_y,
  input  logic [COORD_BITS-1:0]  in_third_x,
  input  logic [COORD_BITS-1:0]  in_third_y,
  input  logic [COLOUR_BITS-1:0] in_fill_colour,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [COORD_BITS-1:0]  out_span_row,
  output logic [COORD_BITS-1:0]  out_span_x_from,
  output logic [COORD_BITS-1:0]  out_span_x_to,
  output logic [COLOUR_BITS-1:0] out_span_colour,
  output logic                   out_last_span
);
  tsr_cmd_t cmd;
  tsr_sts_t sts;
  logic [COORD_BITS-1:0] vx [3], vy [3];

  assign vx = '{in_first_x, in_second_x, in_third_x};
  assign vy = '{in_first_y, in_second_y, in_third_y};

  tsr_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_opcode, .in_ready,
    .out_valid, .out_ready, .sts, .cmd
  );

  tsr_dp #(.COORD_BITS(COORD_BITS)) u_dp (
    .clk, .rst_n, .vx_in(vx), .vy_in(vy), .colour_in(in_fill_colour),
    .cmd, .sts,
    .o_row(out_span_row), .o_xf(out_span_x_from), .o_xt(out_span_x_to),
    .o_col(out_span_colour), .o_last(out_last_span)
  );
endmodule

>>> tb/tb_triangle_span_rasterizer.sv
// Testbench for the triangle span rasterizer: directed and random triangles, span-by-span check.
`timescale 1ns / 1ps

module tb_triangle_span_rasterizer import tsr_pkg::*; ();

  localparam int CB = COORD_BITS_DEF;
  localparam int CMAX = (1 << CB) - 1;
  localparam int EDGE_TWO_CAP = (2 << CB) + 2;
  localparam int RANDOM_ITEMS = 1450;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 2 * CB + 40;

  typedef struct packed {
    logic                   opcode;
    logic [CB-1:0]          first_x;
    logic [CB-1:0]          first_y;
    logic [CB-1:0]          second_x;
    logic [CB-1:0]          second_y;
    logic [CB-1:0]          third_x;
    logic [CB-1:0]          third_y;
    logic [COLOUR_BITS-1:0] fill_colour;
  } tri_item_t;

  typedef struct packed {
    logic [CB-1:0]          row;
    logic [CB-1:0]          x_from;
    logic [CB-1:0]          x_to;
    logic [COLOUR_BITS-1:0] colour;
    logic                   last;
  } span_t;

  // Bresenham walker of one edge
  typedef struct {
    int x, y, err, dmaj, dmin, sx, sy;
    bit steep;
  } edge_walk_t;

  logic clk;
  logic rst_n;

  tsr_if #(.T(tri_item_t)) in_ch ();
  tsr_if #(.T(span_t))     out_ch ();

  triangle_span_rasterizer i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_opcode       (in_ch.data.opcode),
    .in_first_x      (in_ch.data.first_x),
    .in_first_y      (in_ch.data.first_y),
    .in_second_x     (in_ch.data.second_x),
    .in_second_y     (in_ch.data.second_y),
    .in_third_x      (in_ch.data.third_x),
    .in_third_y      (in_ch.data.third_y),
    .in_fill_colour  (in_ch.data.fill_colour),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_span_row    (out_ch.data.row),
    .out_span_x_from (out_ch.data.x_from),
    .out_span_x_to   (out_ch.data.x_to),
    .out_span_colour (out_ch.data.colour),
    .out_last_span   (out_ch.data.last)
  );

  // 8 ns clock
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // ---------------------------------------------------------------------
  // Span predictor: own copy of the rasterizer state
  // ---------------------------------------------------------------------
  bit             tri_active;
  bit             on_final_half;
  int             lower_apex_x, lower_apex_y;
  int             split_x, split_y, mid_x;
  edge_walk_t     edge_one, edge_two;
  int unsigned    spans_left;
  logic [COLOUR_BITS-1:0] held_colour;
  span_t          expected_spans[$];

  int  items_sent;
  int  triangles_loaded;
  int  spans_checked;
  int  error_count;
  bit  no_idle;        // when set, neither side inserts gaps
  int  hold_req;       // bumped by a test to ask for a long receiver hold-off

  function automatic int sign_of(int v);
    if (v > 0) return 1;
    if (v < 0) return -1;
    return 0;
  endfunction

  function automatic edge_walk_t walk_setup(int ax, int ay, int bx, int by);
    edge_walk_t w;
    int dx, dy, t;
    dx = bx - ax;
    dy = by - ay;
    w.sx = sign_of(dx);
    w.sy = sign_of(dy);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    w.steep = dy > dx;
    if (w.steep) begin
      t = dx;
      dx = dy;
      dy = t;
    end
    w.dmaj = dx;
    w.dmin = dy;
    w.err = 2 * dy - dx;
    w.x = ax;
    w.y = ay;
    return w;
  endfunction

  // one major-axis step; the minor-axis catch-up is capped at four moves
  function automatic edge_walk_t walk_step(edge_walk_t w);
    int g;
    g = 0;
    if (w.dmaj == 0) return w;
    while (w.err >= 0 && g < 4) begin
      if (w.steep) w.x += w.sx;
      else w.y += w.sy;
      w.err -= 2 * w.dmaj;
      g++;
    end
    if (w.steep) w.y += w.sy;
    else w.x += w.sx;
    w.err += 2 * w.dmin;
    return w;
  endfunction

  function automatic void begin_half(int ax, int ay, int bx, int by, int cx, int cy);
    edge_one = walk_setup(ax, ay, bx, by);
    edge_two = walk_setup(ax, ay, cx, cy);
    spans_left = edge_one.dmaj + 1;
  endfunction

  function automatic void load_triangle(tri_item_t t);
    int vx[3], vy[3];
    int tmp, i, j;
    vx[0] = t.first_x;  vy[0] = t.first_y;
    vx[1] = t.second_x; vy[1] = t.second_y;
    vx[2] = t.third_x;  vy[2] = t.third_y;
    // descending y, stable
    for (i = 1; i < 3; i++)
      for (j = i; j > 0 && vy[j-1] < vy[j]; j--) begin
        tmp = vx[j]; vx[j] = vx[j-1]; vx[j-1] = tmp;
        tmp = vy[j]; vy[j] = vy[j-1]; vy[j-1] = tmp;
      end
    held_colour = t.fill_colour;
    tri_active = 1'b1;
    if (vy[1] == vy[2]) begin
      on_final_half = 1'b1;
      begin_half(vx[0], vy[0], vx[1], vy[1], vx[2], vy[2]);
    end else if (vy[0] == vy[1]) begin
      on_final_half = 1'b1;
      begin_half(vx[2], vy[2], vx[0], vy[0], vx[1], vy[1]);
    end else begin
      // signed division truncates toward zero, like the hardware divider
      split_x = vx[0] - ((vy[0] - vy[1]) * (vx[0] - vx[2])) / (vy[0] - vy[2]);
      split_y = vy[1];
      mid_x = vx[1];
      lower_apex_x = vx[2];
      lower_apex_y = vy[2];
      on_final_half = 1'b0;
      begin_half(vx[0], vy[0], vx[1], vy[1], split_x, split_y);
    end
  endfunction

  function automatic void predict_span(tri_item_t t);
    span_t s;
    int g;
    if (t.opcode == 1'(OPC_LOAD)) begin
      load_triangle(t);
      return;
    end
    if (!tri_active) return;   // advance with nothing loaded: no span
    s.row = CB'(edge_one.y);
    s.x_from = CB'(edge_one.x);
    s.x_to = CB'(edge_two.x);
    s.colour = held_colour;
    s.last = 1'b0;
    if (spans_left > 0) spans_left--;
    if (spans_left == 0) begin
      if (!on_final_half) begin
        on_final_half = 1'b1;
        begin_half(lower_apex_x, lower_apex_y, mid_x, split_y, split_x, split_y);
      end else begin
        tri_active = 1'b0;
        s.last = 1'b1;
      end
    end else begin
      edge_one = walk_step(edge_one);
      for (g = 0; edge_two.y != edge_one.y && g < EDGE_TWO_CAP; g++)
        edge_two = walk_step(edge_two);
    end
    expected_spans.push_back(s);
  endfunction

  // ---------------------------------------------------------------------
  // Sender: one transfer per call, random gap in front
  // ---------------------------------------------------------------------
  task automatic send_item(tri_item_t t);
    int r, gap;
    r = $urandom_range(0, 99);
    gap = 0;
    if (!no_idle) begin
      if (r >= 95) gap = $urandom_range(8, 40);
      else if (r >= 70) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= t;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (t.opcode == 1'(OPC_LOAD)) triangles_loaded++;
    if (t.opcode == 1'(OPC_LOAD) || tri_active) items_sent++;
    predict_span(t);
  endtask

  task automatic send_load(int ax, int ay, int bx, int by, int cx, int cy, int col);
    tri_item_t t;
    t.opcode = 1'(OPC_LOAD);
    t.first_x = CB'(ax);  t.first_y = CB'(ay);
    t.second_x = CB'(bx); t.second_y = CB'(by);
    t.third_x = CB'(cx);  t.third_y = CB'(cy);
    t.fill_colour = COLOUR_BITS'(col);
    send_item(t);
  endtask

  // advance; the unused fields carry junk so their bits toggle too
  task automatic send_advance();
    tri_item_t t;
    logic [95:0] junk;
    junk = {$urandom, $urandom, $urandom};
    t = junk[$bits(tri_item_t)-1:0];
    t.opcode = 1'(OPC_ADVANCE);
    send_item(t);
  endtask

  task automatic finish_triangle();
    while (tri_active) send_advance();
  endtask

  task automatic draw(int ax, int ay, int bx, int by, int cx, int cy, int col);
    send_load(ax, ay, bx, by, cx, cy, col);
    finish_triangle();
  endtask

  // ---------------------------------------------------------------------
  // Receiver: random stalls plus an on-demand long hold-off
  // ---------------------------------------------------------------------
  int hold_seen;
  int stall_left;

  always @(posedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      stall_left = HOLD_CYCLES;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if (no_idle || r < 60) begin
      out_ch.ready <= 1'b1;
    end else begin
      stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
      out_ch.ready <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------
  // Span checker
  // ---------------------------------------------------------------------
  task automatic report(string field, longint exp_v, longint got_v);
    $display("%0t: %s expected 0x%0h, got 0x%0h", $time, field, exp_v, got_v);
    error_count++;
  endtask

  always @(posedge clk) begin
    span_t exp_s;
    span_t got_s;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got_s = out_ch.data;
      if (expected_spans.size() == 0) begin
        $display("%0t: unexpected span, expected none, got row 0x%0h", $time, got_s.row);
        error_count++;
      end else begin
        exp_s = expected_spans.pop_front();
        spans_checked++;
        if (got_s.row !== exp_s.row) report("span_row", exp_s.row, got_s.row);
        if (got_s.x_from !== exp_s.x_from) report("span_x_from", exp_s.x_from, got_s.x_from);
        if (got_s.x_to !== exp_s.x_to) report("span_x_to", exp_s.x_to, got_s.x_to);
        if (got_s.colour !== exp_s.colour) report("span_colour", exp_s.colour, got_s.colour);
        if (got_s.last !== exp_s.last) report("last_span", exp_s.last, got_s.last);
      end
    end
  end

  // run-away guard
  int cycle_count;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // advances with no triangle loaded must give nothing
  task automatic test_idle_advance();
    send_advance();
    send_advance();
  endtask

  // shapes: point, flat bottom, flat top, split, tie order, steep, shallow, corners
  task automatic test_shapes();
    draw(5, 5, 5, 5, 5, 5, 'h000000);                 // zero-length apex edge
    draw(10, 20, 4, 12, 16, 12, 'hFFFFFF);             // flat bottom
    draw(3, 30, 12, 30, 8, 22, 'h123456);              // flat top
    draw(12, 12, 20, 30, 2, 2, 'hA5A5A5);              // split, middle vertex right
    draw(20, 30, 2, 20, 15, 3, 'h5A5A5A);              // split, middle vertex left
    draw(7, 9, 4, 9, 4, 9, 'h00FF00);                  // all rows tie, input order kept
    draw(CMAX, CMAX, CMAX - 6, CMAX, CMAX, CMAX - 5, 'hFF0000);
    draw(0, 0, 0, 3, 9, 1, 'h0000FF);
    draw(0, 2, 200, 1, 0, 0, 'hC0FFEE);                // very shallow long edges
  endtask

  // a load while a triangle is in flight drops it; big extreme triangle
  task automatic test_reload();
    send_load(0, 0, CMAX, CMAX, 0, CMAX, 'hFFFFFF);
    repeat (4) send_advance();
    send_load(CMAX, 0, 0, CMAX, CMAX, CMAX, 'h000001);
    repeat (3) send_advance();
    draw(1, 1, 3, 4, 6, 2, 'h800000);
  endtask

  // receiver holds off while advances keep coming, so the block backs up
  task automatic test_backpressure();
    send_load(100, 100, 140, 160, 60, 150, 'h3C3C3C);
    hold_req++;
    finish_triangle();
  endtask

  task automatic random_triangle(int max_size);
    int bx, by, sz, col;
    sz = $urandom_range(0, max_size);
    bx = $urandom_range(0, CMAX - sz);
    by = $urandom_range(0, CMAX - sz);
    col = $urandom;
    send_load(bx + $urandom_range(0, sz), by + $urandom_range(0, sz),
              bx + $urandom_range(0, sz), by + $urandom_range(0, sz),
              bx + $urandom_range(0, sz), by + $urandom_range(0, sz), col);
  endtask

  task automatic test_random();
    int r, n;
    while (items_sent < RANDOM_ITEMS) begin
      no_idle = ($urandom_range(0, 99) < 15);
      r = $urandom_range(0, 99);
      if (r < 80) begin
        random_triangle(($urandom_range(0, 19) == 0) ? 150 : 24);
        finish_triangle();
      end else if (r < 92) begin
        // broken sequence: may be cut short by a later load
        random_triangle(40);
        n = $urandom_range(0, 6);
        repeat (n) send_advance();
      end else begin
        // noise: arbitrary item
        if (!tri_active || $urandom_range(0, 1)) send_advance();
        else random_triangle(CMAX);
      end
    end
    finish_triangle();
    no_idle = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    tri_active = 1'b0;
    on_final_half = 1'b0;
    spans_left = 0;
    held_colour = '0;
    no_idle = 1'b0;
    hold_req = 0;
    hold_seen = 0;
    stall_left = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_advance();
    test_shapes();
    test_reload();
    test_backpressure();
    test_random();

    in_ch.valid <= 1'b0;
    while (expected_spans.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d triangles and %0d counted transfers; %0d spans checked.",
             triangles_loaded, items_sent, spans_checked);
    $display("Shapes: point, flat top/bottom, split, ties, edges of the grid, reloads, stalls.");
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
